FILE: sv/stream_id_translation_table_core_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the stream id translation table
// shared property wrappers, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STREAM_ID_TRANSLATION_TABLE_CORE_DEFINES_SVH
`define STREAM_ID_TRANSLATION_TABLE_CORE_DEFINES_SVH

// expression holds at every edge out of reset
`define SITT_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define SITT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sitt_pkg.sv
// ----------------------------------------------------------------------------
// sitt_pkg
// types, codes and the set hash of the stream id translation table
// ----------------------------------------------------------------------------
package sitt_pkg;

  localparam int unsigned BUCKETS     = 64;
  localparam int unsigned WAYS        = 4;
  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned HASH_MUL    = 31;

  localparam int unsigned SET_W  = $clog2(BUCKETS);
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned SLOT_W = SET_W + WAY_W;
  localparam int unsigned H_W    = 8;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned FD_W   = 16;
  localparam int unsigned ST_W   = 31;

  localparam logic [2:0] REQ_CREATE   = 3'd0;
  localparam logic [2:0] REQ_LOOK_IN  = 3'd1;
  localparam logic [2:0] REQ_LOOK_OUT = 3'd2;
  localparam logic [2:0] REQ_DESTROY  = 3'd3;
  localparam logic [2:0] REQ_REMOVE   = 3'd4;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_NOTFOUND = 3'd1;
  localparam logic [2:0] STAT_INVALID  = 3'd2;
  localparam logic [2:0] STAT_DUP_IN   = 3'd3;
  localparam logic [2:0] STAT_DUP_OUT  = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;

  // classified request word passed from front to back
  typedef struct packed {
    logic [2:0]       op;
    logic             bad;
    logic [FD_W-1:0]  kfd;
    logic [ST_W-1:0]  kst;
    logic [FD_W-1:0]  pfd;
    logic [ST_W-1:0]  pst;
    logic [H_W-1:0]   hin;
    logic [SET_W-1:0] set_k;
    logic [SET_W-1:0] set_p;
  } req_t;

  function automatic logic [SET_W-1:0] hash_set(input logic [FD_W-1:0] fd,
                                                input logic [ST_W-1:0] st);
    logic [FD_W+4:0] prod;
    prod = (FD_W+5)'(fd) * (FD_W+5)'(HASH_MUL);
    return prod[SET_W-1:0] ^ st[SET_W-1:0];
  endfunction

endpackage

FILE: sv/sitt_front.sv
// ----------------------------------------------------------------------------
// sitt_front
// accepts request words, checks them and queues them for the back end
// ----------------------------------------------------------------------------
module sitt_front import sitt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic [FD_W-1:0]  key_fd,
  input  logic [ST_W-1:0]  key_stream,
  input  logic [FD_W-1:0]  peer_fd,
  input  logic [ST_W-1:0]  peer_stream,
  input  logic [H_W-1:0]   handle_in,
  output logic             q_valid,
  output req_t             q_data,
  input  logic             q_pop
);

  req_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  req_t       word;
  logic       push;

  always_comb begin
    word.op    = req_type;
    word.kfd   = key_fd;
    word.kst   = key_stream;
    word.pfd   = peer_fd;
    word.pst   = peer_stream;
    word.hin   = handle_in;
    word.set_k = hash_set(key_fd, key_stream);
    word.set_p = hash_set(peer_fd, peer_stream);
    case (req_type)
      REQ_CREATE:                word.bad = (key_stream == '0) || (peer_stream == '0);
      REQ_LOOK_IN, REQ_LOOK_OUT: word.bad = (key_stream == '0);
      REQ_DESTROY, REQ_REMOVE:   word.bad = 1'b0;
      default:                   word.bad = 1'b1;
    endcase
  end

  assign in_stall = (fill == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (q_pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= word;
  end

endmodule

FILE: sv/sitt_back.sv
// ----------------------------------------------------------------------------
// sitt_back
// executes queued requests against the entry pool and both set indexes
// ----------------------------------------------------------------------------
`include "stream_id_translation_table_core_defines.svh"

module sitt_back import sitt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  req_t             q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [H_W-1:0]   handle_out,
  output logic [FD_W-1:0]  match_fd,
  output logic [ST_W-1:0]  match_stream,
  output logic [CNT_W-1:0] removed_count,
  output logic [CNT_W-1:0] entry_count
);

  localparam int unsigned SLOTS = BUCKETS * WAYS;
  localparam int unsigned GRP_W = 4;
  localparam int unsigned BIT_W = H_W - GRP_W;
  localparam int unsigned GRPS  = 1 << GRP_W;
  localparam int unsigned GBITS = 1 << BIT_W;

  typedef struct packed {
    logic [FD_W-1:0]   fd;
    logic [ST_W-1:0]   st;
    logic [H_W-1:0]    h;
  } idx_t;

  typedef struct packed {
    logic [FD_W-1:0]   in_fd;
    logic [ST_W-1:0]   in_st;
    logic [FD_W-1:0]   out_fd;
    logic [ST_W-1:0]   out_st;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] out_slot;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_EDAT, S_FGRP, S_FBIT,
    S_DRD, S_DCHK, S_RRD, S_RCHK, S_DONE
  } state_t;

  function automatic logic [BIT_W-1:0] first_zero_g(input logic [GBITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = GBITS - 1; i >= 0; i--) if (!v[i]) r = BIT_W'(i);
    return r;
  endfunction

  function automatic logic [GRP_W-1:0] first_one_g(input logic [GRPS-1:0] v);
    logic [GRP_W-1:0] r;
    r = '0;
    for (int i = GRPS - 1; i >= 0; i--) if (v[i]) r = GRP_W'(i);
    return r;
  endfunction

  function automatic logic [WAY_W-1:0] first_zero_w(input logic [WAYS-1:0] v);
    logic [WAY_W-1:0] r;
    r = '0;
    for (int i = WAYS - 1; i >= 0; i--) if (!v[i]) r = WAY_W'(i);
    return r;
  endfunction

  // memories
  idx_t in_mem  [SLOTS];
  idx_t out_mem [SLOTS];
  ent_t ent_mem [MAX_ENTRIES];
  idx_t in_rd;
  idx_t out_rd;
  ent_t ent_rd;

  // valid flags, cleared at reset
  logic [MAX_ENTRIES-1:0] evalid;
  logic [SLOTS-1:0]       ival;
  logic [SLOTS-1:0]       oval;
  logic [CNT_W-1:0]       live;

  state_t           state;
  req_t             cur;
  logic             side;
  logic [WAY_W-1:0] way;
  logic [H_W-1:0]   ridx;
  logic [GRP_W-1:0] grp;
  logic             grp_any;
  logic [2:0]       r_status;
  logic [H_W-1:0]   r_hout;
  logic [FD_W-1:0]  r_mfd;
  logic [ST_W-1:0]  r_mst;
  logic [CNT_W-1:0] r_removed;

  logic [FD_W-1:0]   kf;
  logic [ST_W-1:0]   ks;
  logic [SET_W-1:0]  sset;
  logic [SLOT_W-1:0] saddr;
  idx_t              srd;
  logic              hit;
  logic [H_W-1:0]    ent_raddr;
  logic [H_W-1:0]    ent_raddr_hold;
  logic [GRPS-1:0]   grp_free;
  logic [GBITS-1:0]  gbits;
  logic [WAYS-1:0]   iw;
  logic [WAYS-1:0]   ow;
  logic [SLOT_W-1:0] si;
  logic [SLOT_W-1:0] so;
  logic [H_W-1:0]    new_h;
  logic              cr_go;
  logic              unlink;
  logic              out_free;

  always_comb begin
    if (cur.op == REQ_CREATE && side) begin
      kf   = cur.pfd;
      ks   = cur.pst;
      sset = cur.set_p;
    end else begin
      kf   = cur.kfd;
      ks   = cur.kst;
      sset = cur.set_k;
    end
    saddr = {sset, way};
    srd   = side ? out_rd : in_rd;
    hit   = (side ? oval[saddr] : ival[saddr]) && srd.fd == kf && srd.st == ks;
    case (state)
      S_DRD:   ent_raddr = cur.hin;
      S_RRD:   ent_raddr = ridx;
      default: ent_raddr = srd.h;
    endcase
    for (int g = 0; g < GRPS; g++) grp_free[g] = ~&evalid[g*GBITS +: GBITS];
    gbits  = evalid[{grp, BIT_W'(0)} +: GBITS];
    new_h  = {grp, first_zero_g(gbits)};
    iw     = ival[{cur.set_k, WAY_W'(0)} +: WAYS];
    ow     = oval[{cur.set_p, WAY_W'(0)} +: WAYS];
    si     = {cur.set_k, first_zero_w(iw)};
    so     = {cur.set_p, first_zero_w(ow)};
    cr_go  = (state == S_FBIT) && grp_any && !(&iw) && !(&ow);
    unlink = (state == S_DCHK) ||
             ((state == S_RCHK) && evalid[ridx] &&
              (ent_rd.in_fd == cur.kfd || ent_rd.out_fd == cur.kfd));
    out_free = !out_valid || !out_stall;
    q_pop    = (state == S_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (state == S_SRD) begin
      in_rd  <= in_mem[saddr];
      out_rd <= out_mem[saddr];
    end
    ent_rd <= ent_mem[ent_raddr];
    if (cr_go) begin
      in_mem[si]     <= '{fd: cur.kfd, st: cur.kst, h: new_h};
      out_mem[so]    <= '{fd: cur.pfd, st: cur.pst, h: new_h};
      ent_mem[new_h] <= '{in_fd: cur.kfd, in_st: cur.kst, out_fd: cur.pfd,
                          out_st: cur.pst, in_slot: si, out_slot: so};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      evalid    <= '0;
      ival      <= '0;
      oval      <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;
      if (unlink) begin
        ival[ent_rd.in_slot]   <= 1'b0;
        oval[ent_rd.out_slot]  <= 1'b0;
        evalid[ent_raddr_hold] <= 1'b0;
        live                   <= live - 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur       <= q_data;
            side      <= (q_data.op == REQ_LOOK_OUT);
            way       <= '0;
            ridx      <= '0;
            r_hout    <= '0;
            r_mfd     <= '0;
            r_mst     <= '0;
            r_removed <= '0;
            if (q_data.bad) begin
              r_status <= STAT_INVALID;
              state    <= S_DONE;
            end else begin
              r_status <= STAT_OK;
              case (q_data.op)
                REQ_DESTROY: state <= S_DRD;
                REQ_REMOVE:  state <= S_RRD;
                default:     state <= S_SRD;
              endcase
            end
          end
        end
        S_SRD: state <= S_SCMP;
        S_SCMP: begin
          if (hit) begin
            if (cur.op == REQ_CREATE) begin
              r_status <= side ? STAT_DUP_OUT : STAT_DUP_IN;
              state    <= S_DONE;
            end else begin
              r_hout <= srd.h;
              state  <= S_EDAT;
            end
          end else if (way == WAY_W'(WAYS - 1)) begin
            way <= '0;
            if (cur.op != REQ_CREATE) begin
              r_status <= STAT_NOTFOUND;
              state    <= S_DONE;
            end else if (!side) begin
              side  <= 1'b1;
              state <= S_SRD;
            end else begin
              state <= S_FGRP;
            end
          end else begin
            way   <= way + 1'b1;
            state <= S_SRD;
          end
        end
        S_EDAT: begin
          if (cur.op == REQ_LOOK_IN) begin
            r_mfd <= ent_rd.out_fd;
            r_mst <= ent_rd.out_st;
          end else begin
            r_mfd <= ent_rd.in_fd;
            r_mst <= ent_rd.in_st;
          end
          state <= S_DONE;
        end
        S_FGRP: begin
          grp     <= first_one_g(grp_free);
          grp_any <= |grp_free;
          state   <= S_FBIT;
        end
        S_FBIT: begin
          if (cr_go) begin
            evalid[new_h] <= 1'b1;
            ival[si]      <= 1'b1;
            oval[so]      <= 1'b1;
            live          <= live + 1'b1;
            r_hout        <= new_h;
          end else begin
            r_status <= STAT_FULL;
          end
          state <= S_DONE;
        end
        S_DRD: begin
          if (evalid[cur.hin]) begin
            state <= S_DCHK;
          end else begin
            r_status <= STAT_NOTFOUND;
            state    <= S_DONE;
          end
        end
        S_DCHK: begin
          r_hout <= cur.hin;
          state  <= S_DONE;
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (unlink) r_removed <= r_removed + 1'b1;
          ridx <= ridx + 1'b1;
          state <= (ridx == H_W'(MAX_ENTRIES - 1)) ? S_DONE : S_RRD;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= r_status;
            handle_out    <= r_hout;
            match_fd      <= r_mfd;
            match_stream  <= r_mst;
            removed_count <= r_removed;
            entry_count   <= live;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // entry being unlinked: the handle of a destroy or the removal walk position
  assign ent_raddr_hold = (state == S_DCHK) ? cur.hin : ridx;

  `SITT_ASSERT_ALWAYS(a_live_bound, clk, rst, live <= CNT_W'(MAX_ENTRIES), "live count above pool size")
  `SITT_ASSERT_NEXT(a_pop_leaves_idle, clk, rst, q_pop, state != S_IDLE, "popped word not taken up")
  `SITT_ASSERT_NEXT(a_done_delivers, clk, rst, state == S_DONE && !out_valid, out_valid && state == S_IDLE, "result not loaded")

endmodule

FILE: sv/stream_id_translation_table_core.sv
// lookups probe the key's set with one index memory read per way, so the way count sets
// lookup time, then read the entry; create probes both sets, then picks a free handle;
// destroy checks its handle; rejected words skip to the result; removal walks all entries
// one request at a time in the back end; the two-word front queue accepts until full
// rst is synchronous: entry and index slot valid flags and the live count are cleared at once
// ----------------------------------------------------------------------------
// stream_id_translation_table_core
// dual key set-associative mapping table for inbound and outbound stream ids
// ----------------------------------------------------------------------------
module stream_id_translation_table_core import sitt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  // request word channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       req_type,
  input  logic [FD_W-1:0]  key_fd,
  input  logic [ST_W-1:0]  key_stream,
  input  logic [FD_W-1:0]  peer_fd,
  input  logic [ST_W-1:0]  peer_stream,
  input  logic [H_W-1:0]   handle_in,
  // result word channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       status,
  output logic [H_W-1:0]   handle_out,
  output logic [FD_W-1:0]  match_fd,
  output logic [ST_W-1:0]  match_stream,
  output logic [CNT_W-1:0] removed_count,
  output logic [CNT_W-1:0] entry_count
);

  // front to back queue interface
  logic q_valid;
  logic q_pop;
  req_t q_data;

  // front: validity checks and both set hashes, then a two-word queue
  sitt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key_fd      (key_fd),
    .key_stream  (key_stream),
    .peer_fd     (peer_fd),
    .peer_stream (peer_stream),
    .handle_in   (handle_in),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop)
  );

  // back: sequencer over the entry pool and the inbound and outbound indexes,
  // with a registered result word toward the consumer
  sitt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .handle_out    (handle_out),
    .match_fd      (match_fd),
    .match_stream  (match_stream),
    .removed_count (removed_count),
    .entry_count   (entry_count)
  );

endmodule
